// ===== design/sine_beep_generator_defines.svh =====
// Assertion macros shared by the tone generator modules.
`ifndef SINE_BEEP_GENERATOR_DEFINES_SVH
`define SINE_BEEP_GENERATOR_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define SBG_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SBG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SBG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbg_pkg;

  // Phase accumulator and sine table geometry.
  localparam int PHASE_BITS     = 32;
  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_ADDR_BITS = $clog2(SINE_DEPTH);

  // Field widths.
  localparam int BEEP_BITS   = 13;
  localparam int ENV_BITS    = 12;
  localparam int LEVEL_BITS  = 16;
  localparam int STEP_BITS   = 31;
  localparam int SAMPLE_BITS = 16;
  localparam int QUO_BITS    = 15;

  // Largest sample magnitude: 32767 * 65535 * 3 / 327680, rounded down.
  localparam logic [QUO_BITS-1:0] QUO_MAX = 15'd19659;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEEP_LENGTH    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_LENGTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_LENGTH = 2'd2;

  // Reset values.
  localparam logic [BEEP_BITS-1:0]  BEEP_LENGTH_RESET    = 13'd5292;
  localparam logic [ENV_BITS-1:0]   ATTACK_LENGTH_RESET  = 12'd200;
  localparam logic [ENV_BITS-1:0]   RELEASE_LENGTH_RESET = 12'd200;
  localparam logic [PHASE_BITS-1:0] STEP_RESET           = PHASE_BITS'(21426142);
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET          = 16'd19661;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One sample job handed from the front to the back.
  typedef struct packed {
    logic                      silent;
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [LEVEL_BITS-1:0]     level;
    logic [ENV_BITS-1:0]       num;
    logic [ENV_BITS-1:0]       den;
  } sbg_job_t;

  typedef logic signed [SAMPLE_BITS-1:0] sine_rom_t [SINE_DEPTH];

  // Q30 angle constants for the table builder.
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  // One table entry: round(32767 * sin(angle)) from a Taylor series in Q30.
  function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(
    input logic [SINE_ADDR_BITS-1:0] idx
  );
    longint a;
    logic neg;
    longint unsigned xm;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    a = (longint'(idx) * Q30_TWO_PI) / SINE_DEPTH;
    if (a > Q30_PI) a = a - Q30_TWO_PI;
    if (a > Q30_HALF_PI) a = Q30_PI - a;
    else if (a < -Q30_HALF_PI) a = -Q30_PI - a;
    neg  = (a < 0);
    xm   = neg ? longint'(-a) : a;
    x2   = (xm * xm) >> 30;
    term = xm;
    sum  = xm;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    if (sum > Q30_ONE) sum = Q30_ONE;
    sum = (sum * 32767 + 64'sd536870912) >>> 30;
    if (neg) sum = -sum;
    return SAMPLE_BITS'(sum);
  endfunction

  // Whole sine table, built at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      rom[i] = sine_entry(SINE_ADDR_BITS'(i));
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ===== design/sbg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sine_beep_generator_defines.svh"

module sbg_queue
  import sbg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire sbg_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output sbg_job_t      head_job
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  sbg_job_t             mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;

  assign full       = (count == CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SBG_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_BITS'(QUEUE_DEPTH), "queue overfilled")
  `SBG_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

// ===== design/sbg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sine_beep_generator_defines.svh"

module sbg_front
  import sbg_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [47:0]               s_tdata,
  input  wire logic [0:0]                s_tuser,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [BEEP_BITS-1:0]      cfg_data,
  input  wire logic                      queue_full,
  output logic                           push,
  output sbg_job_t                       push_job
);

  logic [BEEP_BITS-1:0]  beep_length;
  logic [ENV_BITS-1:0]   attack_length;
  logic [ENV_BITS-1:0]   release_length;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] step_word;
  logic [LEVEL_BITS-1:0] level;
  logic [BEEP_BITS-1:0]  remaining;

  logic                  accept;
  logic                  trigger;
  logic                  tick;
  logic [STEP_BITS-1:0]  in_step;
  logic [LEVEL_BITS-1:0] in_volume;
  logic [PHASE_BITS-1:0] phase_next;
  logic [BEEP_BITS-1:0]  age;
  logic [ENV_BITS-1:0]   num;
  logic [ENV_BITS-1:0]   den;

  assign s_tready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign trigger   = accept && s_tuser[0];
  assign tick      = accept && !s_tuser[0];
  assign in_step   = s_tdata[STEP_BITS-1:0];
  assign in_volume = s_tdata[STEP_BITS +: LEVEL_BITS];

  assign phase_next = phase_acc + step_word;

  // Envelope fraction from the position within the beep.
  always_comb begin
    age = (remaining > beep_length) ? '0 : beep_length - remaining;
    if (age < {1'b0, attack_length}) begin
      num = age[ENV_BITS-1:0];
      den = attack_length;
    end else if (remaining < {1'b0, release_length}) begin
      num = remaining[ENV_BITS-1:0];
      den = release_length;
    end else begin
      num = ENV_BITS'(1);
      den = ENV_BITS'(1);
    end
  end

  // Every tick becomes one job for the back.
  assign push            = tick;
  assign push_job.silent = (remaining == '0);
  assign push_job.addr   = phase_next[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign push_job.level  = level;
  assign push_job.num    = num;
  assign push_job.den    = den;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      beep_length    <= BEEP_LENGTH_RESET;
      attack_length  <= ATTACK_LENGTH_RESET;
      release_length <= RELEASE_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BEEP_LENGTH:    beep_length    <= cfg_data;
        REG_ATTACK_LENGTH:  attack_length  <= cfg_data[ENV_BITS-1:0];
        REG_RELEASE_LENGTH: release_length <= cfg_data[ENV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Oscillator and beep state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      step_word <= STEP_RESET;
      level     <= LEVEL_RESET;
      remaining <= '0;
    end else if (trigger) begin
      step_word <= {1'b0, in_step};
      level     <= in_volume;
      remaining <= beep_length;
    end else if (tick && remaining != '0) begin
      phase_acc <= phase_next;
      remaining <= remaining - 1'b1;
    end
  end

  `SBG_ASSERT_NEXT(a_trig_reload, clk, rst, trigger, remaining == $past(beep_length), "trigger did not reload the beep count")
  `SBG_ASSERT_IMPL(a_env_frac, clk, rst, tick && remaining != '0, num <= den, "envelope above one")

endmodule

`default_nettype wire

// ===== design/sbg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sine_beep_generator_defines.svh"

module sbg_back
  import sbg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   head_valid,
  input  wire sbg_job_t               head_job,
  output logic                        pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [SAMPLE_BITS-1:0]      m_tdata
);

  localparam int PROD1_BITS = (QUO_BITS) + LEVEL_BITS;
  localparam int NUM3_BITS  = ENV_BITS + 2;
  localparam int REM_BITS   = PROD1_BITS + NUM3_BITS;
  localparam int DEN5_BITS  = ENV_BITS + 3;
  localparam int CNT_BITS   = $clog2(QUO_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [2:0]                    state;
  logic signed [SAMPLE_BITS-1:0] rom_data;
  logic [LEVEL_BITS-1:0]         level;
  logic [NUM3_BITS-1:0]          num3;
  logic                          neg;
  logic [PROD1_BITS-1:0]         prod1;
  logic [REM_BITS-1:0]           rem;
  logic [REM_BITS-1:0]           dsh;
  logic [QUO_BITS-1:0]           quo;
  logic [CNT_BITS-1:0]           cnt;
  logic [QUO_BITS-1:0]           mag;
  logic [DEN5_BITS-1:0]          den5;
  logic                          out_free;

  assign pop      = (state == S_IDLE) && head_valid;
  assign mag      = rom_data[SAMPLE_BITS-1] ? QUO_BITS'(-rom_data) : rom_data[QUO_BITS-1:0];
  assign den5     = {1'b0, head_job.den, 2'b00} + DEN5_BITS'(head_job.den);
  assign out_free = !m_tvalid || m_tready;

  // Sine table read, registered.
  always_ff @(posedge clk) begin
    if (pop) begin
      rom_data <= SINE_ROM[head_job.addr];
    end
  end

  // Multiply, then divide by 327680 times the envelope denominator,
  // one quotient bit per cycle.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) begin
          level <= head_job.level;
          num3  <= {1'b0, head_job.num, 1'b0} + NUM3_BITS'(head_job.num);
          dsh   <= {den5, 30'b0};
          neg   <= 1'b0;
          quo   <= '0;
        end
      end
      S_MUL1: begin
        prod1 <= PROD1_BITS'(mag) * PROD1_BITS'(level);
        neg   <= rom_data[SAMPLE_BITS-1];
      end
      S_MUL2: begin
        rem <= REM_BITS'(prod1) * REM_BITS'(num3);
        cnt <= CNT_BITS'(QUO_BITS - 1);
      end
      S_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QUO_BITS-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_BITS-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= head_job.silent ? S_DONE : S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_DIV;
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: holds a finished sample until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= neg ? -{1'b0, quo} : {1'b0, quo};
    end
  end

  `SBG_ASSERT_NEXT(a_div_end, clk, rst, state == S_DIV && cnt == '0, state == S_DONE, "divider overran")
  `SBG_ASSERT_IMPL(a_quo_range, clk, rst, state == S_DONE, quo <= QUO_MAX, "sample magnitude out of range")

endmodule

`default_nettype wire

// ===== design/sine_beep_generator.sv =====
// Tick path: job queue, sine table read, two multiply steps, the divider, then the output register;
// a tick outside a beep goes from the queue straight to the output register as a zero sample.
// The back takes a new job only when idle; its divider yields one quotient bit a cycle. A trigger gives no sample.
// A two-entry job queue lets input transfers continue while the back end works.
// Reset (rst, synchronous): phase 0, 220 Hz step, volume 0.3, no beep, register defaults.
`timescale 1ns / 1ps
`default_nettype none

module sine_beep_generator
  import sbg_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [47:0]               s_tdata,   // phase_step[30:0], volume[46:31], zero[47]
  input  wire logic [0:0]                s_tuser,   // action[0]
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [SAMPLE_BITS-1:0]         m_tdata,   // sample[15:0]
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [BEEP_BITS-1:0]      cfg_data
);

  logic     push;
  sbg_job_t push_job;
  logic     queue_full;
  logic     pop;
  logic     head_valid;
  sbg_job_t head_job;

  // Front: input transfers, oscillator and envelope.
  sbg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Job queue between front and back.
  sbg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: table lookup, scaling and output register.
  sbg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire
